// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the HDR tone mapper.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge.
`define RTM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge.
`define RTM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rtm_pkg.sv =====
// Shared constants and types of the HDR Reinhard tone mapper.
// No dependencies; used by the divider, scale, gamma and top files and the testbench.
package rtm_pkg;

  localparam int CH_W        = 32;
  localparam int EXPO_W      = 12;
  localparam int CAP_W       = 18;
  localparam int R_W         = 16;
  localparam int Q2_W        = 33;
  localparam int K_W         = 34;
  localparam int S_W         = 33;
  localparam int V_W         = 51;
  localparam int MHI_W       = 18;
  localparam int DIV_STAGES  = 33;
  localparam int GAMMA_STEPS = 8;

  localparam logic [EXPO_W-1:0] EXPO_MAX   = 12'd2560;
  localparam logic [EXPO_W-1:0] EXPO_RESET = 12'd2560;
  localparam logic [CH_W-1:0]   CHAN_CAP   = 32'h0002_0000;
  localparam logic [K_W-1:0]    K_CAP      = 34'h2_0000_0000;
  localparam logic [K_W-1:0]    ONE_Q      = 34'h0_0001_0000;
  localparam logic [S_W-1:0]    S_CAP      = 33'h1_0000_0000;
  localparam logic [15:0]       GAIN_255SQ = 16'd65025;

  typedef logic [CAP_W-1:0] chan_cap_t;

  typedef struct packed {
    chan_cap_t r;
    chan_cap_t g;
    chan_cap_t b;
  } rgb_cap_t;

  typedef struct packed {
    logic [R_W-1:0]  r;
    logic [Q2_W-1:0] q2;
    logic            ovf;
    logic            plain;
    rgb_cap_t        chans;
  } div_res_t;

  typedef struct packed {
    logic [V_W-1:0] vr;
    logic [V_W-1:0] vg;
    logic [V_W-1:0] vb;
  } rgb_lin_t;

endpackage

// ===== design/rtm_if.sv =====
// Streaming interfaces of the HDR tone mapper: linear pixel in, 8-bit pixel out.
// No dependencies.
interface rtm_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] red_in;
  logic [31:0] green_in;
  logic [31:0] blue_in;
  modport source(output valid, red_in, green_in, blue_in, input ready);
  modport sink(input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rtm_rgb8_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  modport source(output valid, red_out, green_out, blue_out, input ready);
  modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== design/rtm_div_pipe.sv =====
// Pipelined restoring dividers, one quotient bit per stage: L/(1+L) and L*2^8/E.
// Depends on rtm_pkg.
module rtm_div_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [rtm_pkg::CH_W-1:0]    big,
  input  logic [rtm_pkg::EXPO_W-1:0]  expo,
  input  logic                        plain,
  input  rtm_pkg::rgb_cap_t           chans,
  output logic                        out_valid,
  output rtm_pkg::div_res_t           res
);

  typedef struct packed {
    logic [32:0]                 d1;
    logic [32:0]                 rem1;
    logic [rtm_pkg::R_W-1:0]     r;
    logic [rtm_pkg::EXPO_W-1:0]  e;
    logic [rtm_pkg::EXPO_W-1:0]  rem2;
    logic [32:0]                 num2;
    logic [rtm_pkg::Q2_W-1:0]    q2;
    logic                        ovf;
    logic                        plain;
    rtm_pkg::rgb_cap_t           chans;
  } stage_t;

  stage_t s_in;
  stage_t st  [rtm_pkg::DIV_STAGES];
  logic   vld [rtm_pkg::DIV_STAGES];

  always_comb begin
    s_in.d1    = {1'b0, big} + 33'h0_0001_0000;
    s_in.rem1  = {1'b0, big};
    s_in.r     = '0;
    s_in.e     = expo;
    s_in.rem2  = {5'b0, big[31:25]};
    s_in.num2  = {big[24:0], 8'b0};
    s_in.q2    = '0;
    s_in.ovf   = ({5'b0, big[31:25]} >= expo);
    s_in.plain = plain;
    s_in.chans = chans;
  end

  for (genvar t = 0; t < rtm_pkg::DIV_STAGES; t++) begin : g_stage
    stage_t      prev;
    stage_t      nxt;
    logic        prev_vld;
    logic [33:0] sh1;
    logic [12:0] sh2;
    logic        ge1;
    logic        ge2;

    if (t == 0) begin : g_first
      assign prev     = s_in;
      assign prev_vld = in_valid;
    end else begin : g_rest
      assign prev     = st[t-1];
      assign prev_vld = vld[t-1];
    end

    always_comb begin
      nxt = prev;
      sh1 = {prev.rem1, 1'b0};
      ge1 = (sh1 >= {1'b0, prev.d1});
      // The first divider needs only sixteen quotient bits.
      if (t < rtm_pkg::R_W) begin
        nxt.rem1 = ge1 ? 33'(sh1 - {1'b0, prev.d1}) : sh1[32:0];
        nxt.r    = {prev.r[rtm_pkg::R_W-2:0], ge1};
      end
      sh2      = {prev.rem2, prev.num2[32]};
      ge2      = (sh2 >= {1'b0, prev.e});
      nxt.rem2 = ge2 ? 12'(sh2 - {1'b0, prev.e}) : sh2[11:0];
      nxt.num2 = {prev.num2[31:0], 1'b0};
      nxt.q2   = {prev.q2[rtm_pkg::Q2_W-2:0], ge2};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[t] <= 1'b0;
      end else if (adv) begin
        vld[t] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[t] <= nxt;
      end
    end
  end

  assign out_valid = vld[rtm_pkg::DIV_STAGES-1];
  always_comb begin
    res.r     = st[rtm_pkg::DIV_STAGES-1].r;
    res.q2    = st[rtm_pkg::DIV_STAGES-1].q2;
    res.ovf   = st[rtm_pkg::DIV_STAGES-1].ovf;
    res.plain = st[rtm_pkg::DIV_STAGES-1].plain;
    res.chans = st[rtm_pkg::DIV_STAGES-1].chans;
  end

endmodule

// ===== design/rtm_scale.sv =====
// Scale factor and per-channel product stages of the tone mapper.
// Depends on rtm_pkg.
module rtm_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  rtm_pkg::div_res_t  din,
  output logic               out_valid,
  output rtm_pkg::rgb_lin_t  lin
);

  logic [3:0] vld;

  // Stage K: 1 + L/E, saturated.
  logic [rtm_pkg::K_W-1:0] k_sum;
  logic [rtm_pkg::K_W-1:0] k_q;
  logic [rtm_pkg::R_W-1:0] r_k;
  logic                    plain_k;
  rtm_pkg::rgb_cap_t       chans_k;

  // Stage P: r * k.
  logic [49:0]             prod_q;
  logic [rtm_pkg::R_W-1:0] r_p;
  logic                    plain_p;
  rtm_pkg::rgb_cap_t       chans_p;

  // Stage S: the scale.
  logic [33:0]             prod_sh;
  logic [rtm_pkg::S_W-1:0] s_next;
  logic [rtm_pkg::S_W-1:0] s_q;
  rtm_pkg::rgb_cap_t       chans_s;

  assign k_sum   = {1'b0, din.q2} + rtm_pkg::ONE_Q;
  assign prod_sh = prod_q[49:16];

  always_comb begin
    if (plain_p) begin
      s_next = {17'b0, r_p};
    end else if (prod_sh > {1'b0, rtm_pkg::S_CAP}) begin
      s_next = rtm_pkg::S_CAP;
    end else begin
      s_next = prod_sh[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_q     <= (din.ovf || k_sum > rtm_pkg::K_CAP) ? rtm_pkg::K_CAP : k_sum;
      r_k     <= din.r;
      plain_k <= din.plain;
      chans_k <= din.chans;

      prod_q  <= {34'b0, r_k} * {16'b0, k_q};
      r_p     <= r_k;
      plain_p <= plain_k;
      chans_p <= chans_k;

      s_q     <= s_next;
      chans_s <= chans_p;

      lin.vr  <= {33'b0, chans_s.r} * {18'b0, s_q};
      lin.vg  <= {33'b0, chans_s.g} * {18'b0, s_q};
      lin.vb  <= {33'b0, chans_s.b} * {18'b0, s_q};
    end
  end

  assign out_valid = vld[3];

endmodule

// ===== design/rtm_gamma.sv =====
// Square-root gamma and 8-bit quantization, one result bit per stage.
// Depends on rtm_pkg.
module rtm_gamma (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  rtm_pkg::rgb_lin_t  lin,
  output logic               out_valid,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);

  typedef struct packed {
    logic                        sat;
    logic [rtm_pkg::MHI_W-1:0]   mhi;
    logic [7:0]                  n;
  } lane_t;

  localparam int LANES = 3;

  lane_t ln  [rtm_pkg::GAMMA_STEPS+1][LANES];
  logic  vld [rtm_pkg::GAMMA_STEPS+1];
  lane_t l0  [LANES];
  logic [rtm_pkg::V_W-1:0] vin [LANES];

  assign vin[0] = lin.vr;
  assign vin[1] = lin.vg;
  assign vin[2] = lin.vb;

  // 255^2 * v, keeping only the bits above 2^30 that the squares compare to.
  always_comb begin
    logic [47:0] m;
    for (int c = 0; c < LANES; c++) begin
      m        = {16'b0, vin[c][31:0]} * {32'b0, rtm_pkg::GAIN_255SQ};
      l0[c].sat = (vin[c][rtm_pkg::V_W-1:32] != '0);
      l0[c].mhi = m[47:30];
      l0[c].n   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ln[0] <= l0;
    end
  end

  for (genvar b = 0; b < rtm_pkg::GAMMA_STEPS; b++) begin : g_step
    lane_t nxt [LANES];

    always_comb begin
      logic [7:0]  cand;
      logic [8:0]  d;
      logic [17:0] dd;
      for (int c = 0; c < LANES; c++) begin
        cand   = ln[b][c].n | (8'h80 >> b);
        d      = {cand, 1'b0} - 9'd1;
        dd     = {9'b0, d} * {9'b0, d};
        nxt[c] = ln[b][c];
        if (dd <= ln[b][c].mhi) begin
          nxt[c].n = cand;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[b+1] <= 1'b0;
      end else if (adv) begin
        vld[b+1] <= vld[b];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ln[b+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[rtm_pkg::GAMMA_STEPS];
  assign red   = ln[rtm_pkg::GAMMA_STEPS][0].sat ? 8'hFF : ln[rtm_pkg::GAMMA_STEPS][0].n;
  assign green = ln[rtm_pkg::GAMMA_STEPS][1].sat ? 8'hFF : ln[rtm_pkg::GAMMA_STEPS][1].n;
  assign blue  = ln[rtm_pkg::GAMMA_STEPS][2].sat ? 8'hFF : ln[rtm_pkg::GAMMA_STEPS][2].n;

endmodule

// ===== design/hdr_reinhard_tone_mapper.sv =====
// Reinhard tone mapper with a gamma of 2, fully pipelined, one pixel per clock while the receiver does not stall.
// Depends on rtm_pkg, rtm_if, rtm_div_pipe, rtm_scale, rtm_gamma, assert_macros.svh.
//
// Usage:
//   Linear HDR pixels (three unsigned Q16.16 channels) arrive on the pix channel and
//   8-bit tone-mapped pixels leave on the rgb channel; both use a valid/ready
//   handshake, and a transaction completes when valid and ready are both high.
//   The exposure register (Q4.8) is written through cfg_we/cfg_wdata; a value of
//   2560 or more selects plain Reinhard. Write it only while no pixel is in flight.
// Pipeline and throughput:
//   While the receiver does not stall, a new pixel is accepted in every cycle.
//   A pixel passes, in order, through the entry register (loaded at the accepting
//   edge itself), the two restoring dividers (33 stages, one quotient bit each),
//   four stages of scale arithmetic, nine gamma stages (one product and eight
//   square-root steps) and the output register.
// Stalls and reset:
//   When the output holds a pixel the receiver has not taken, the whole pipeline
//   freezes and pix.ready drops, so nothing is lost or repeated.
//   Synchronous reset empties the pipeline and sets the exposure to 2560.
`include "assert_macros.svh"

module hdr_reinhard_tone_mapper (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rtm_pkg::EXPO_W-1:0] cfg_wdata,
  rtm_pix_if.sink                    pix,
  rtm_rgb8_if.source                 rgb
);

  // Exposure register.
  logic [rtm_pkg::EXPO_W-1:0] exposure;

  // The pipeline advances whenever the output register is empty or being drained.
  logic adv;

  // Entry stage: capped channels, the largest channel, and the exposure mode.
  logic                       a_vld;
  logic [rtm_pkg::CH_W-1:0]   a_big;
  logic [rtm_pkg::EXPO_W-1:0] a_expo;
  logic                       a_plain;
  rtm_pkg::rgb_cap_t          a_chans;
  logic [rtm_pkg::CH_W-1:0]   big_rg;
  logic [rtm_pkg::CH_W-1:0]   big_next;

  logic              div_vld;
  rtm_pkg::div_res_t div_res;
  logic              scl_vld;
  rtm_pkg::rgb_lin_t scl_lin;
  logic              gam_vld;
  logic [7:0]        gam_r;
  logic [7:0]        gam_g;
  logic [7:0]        gam_b;

  function automatic rtm_pkg::chan_cap_t cap_chan(input logic [rtm_pkg::CH_W-1:0] c);
    // Anything above 2.0 saturates the output anyway.
    return (c > rtm_pkg::CHAN_CAP) ? rtm_pkg::CHAN_CAP[rtm_pkg::CAP_W-1:0]
                                   : c[rtm_pkg::CAP_W-1:0];
  endfunction

  assign adv       = !rgb.valid || rgb.ready;
  assign pix.ready = adv;

  assign big_rg   = (pix.green_in > pix.red_in) ? pix.green_in : pix.red_in;
  assign big_next = (pix.blue_in > big_rg) ? pix.blue_in : big_rg;

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure <= rtm_pkg::EXPO_RESET;
    end else if (cfg_we) begin
      exposure <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_big     <= big_next;
      // A zero exposure behaves as the smallest step, 1/256.
      a_expo    <= (exposure == '0) ? rtm_pkg::EXPO_W'(1) : exposure;
      a_plain   <= (exposure >= rtm_pkg::EXPO_MAX);
      a_chans.r <= cap_chan(pix.red_in);
      a_chans.g <= cap_chan(pix.green_in);
      a_chans.b <= cap_chan(pix.blue_in);
    end
  end

  rtm_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (a_vld),
    .big       (a_big),
    .expo      (a_expo),
    .plain     (a_plain),
    .chans     (a_chans),
    .out_valid (div_vld),
    .res       (div_res)
  );

  rtm_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (div_vld),
    .din       (div_res),
    .out_valid (scl_vld),
    .lin       (scl_lin)
  );

  rtm_gamma u_gamma (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (scl_vld),
    .lin       (scl_lin),
    .out_valid (gam_vld),
    .red       (gam_r),
    .green     (gam_g),
    .blue      (gam_b)
  );

  // Output register; it holds its pixel while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      rgb.valid <= 1'b0;
    end else if (adv) begin
      rgb.valid <= gam_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rgb.red_out   <= gam_r;
      rgb.green_out <= gam_g;
      rgb.blue_out  <= gam_b;
    end
  end

  `RTM_ASSERT_IMP(a_stall_blocks_input, clk, rst, rgb.valid && !rgb.ready,
                  !pix.ready, "input accepted while output stalled")
  `RTM_ASSERT_IMP(a_empty_takes_input, clk, rst, !rgb.valid,
                  pix.ready, "input refused while output register empty")
  `RTM_ASSERT_NXT(a_drain_empties, clk, rst, rgb.valid && rgb.ready && !gam_vld,
                  !rgb.valid, "output pixel repeated after transaction")
  `RTM_ASSERT_NXT(a_reset_state, clk, 1'b0, rst,
                  exposure == rtm_pkg::EXPO_RESET && !rgb.valid,
                  "reset did not restore exposure or empty output")

endmodule

// ===== verif/hdr_reinhard_tone_mapper_tb.sv =====
// Self-checking testbench of the HDR Reinhard tone mapper: random and directed pixels
// against a bit-exact predictor. Depends on rtm_pkg, rtm_if and hdr_reinhard_tone_mapper.
module hdr_reinhard_tone_mapper_tb;

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] g;
    logic [31:0] b;
  } hdr_pix_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } ldr_pix_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rtm_pkg::EXPO_W-1:0] cfg_wdata = '0;

  rtm_pix_if  pix();
  rtm_rgb8_if rgb();

  hdr_reinhard_tone_mapper u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pix(pix.sink), .rgb(rgb.source)
  );

  // The predictor keeps its own copy of the exposure register.
  logic [rtm_pkg::EXPO_W-1:0] exposure_shadow = rtm_pkg::EXPO_RESET;

  hdr_pix_t pending_pixels[$];
  ldr_pix_t expected_pixels[$];
  int  error_count = 0;
  bit  calm_tail = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  idle_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Round-half-up of 255*sqrt(v/2^32), saturated at 255.
  function automatic logic [7:0] gamma_code(logic [63:0] v);
    logic [63:0] n;
    logic [63:0] cand;
    logic [127:0] lhs;
    logic [127:0] rhs;
    if (v >= 64'h1_0000_0000) return 8'd255;
    n = 0;
    for (int bitpos = 7; bitpos >= 0; bitpos--) begin
      cand = n | (64'd1 << bitpos);
      lhs = 128'(2 * cand - 1) * 128'(2 * cand - 1);
      lhs = lhs << 30;
      rhs = 128'(65025) * 128'(v);
      if (lhs <= rhs) n = cand;
    end
    return n[7:0];
  endfunction

  function automatic ldr_pix_t tone_map(hdr_pix_t p, logic [rtm_pkg::EXPO_W-1:0] expo);
    logic [63:0] ch[3];
    logic [63:0] big, ratio, scale, e, k, c;
    logic [127:0] prod;
    logic [7:0] q[3];
    ch[0] = p.r; ch[1] = p.g; ch[2] = p.b;
    big = ch[0];
    if (ch[1] > big) big = ch[1];
    if (ch[2] > big) big = ch[2];
    ratio = (big << 16) / (64'h1_0000 + big);
    e = expo;
    if (e == 0) e = 1;
    if (e >= rtm_pkg::EXPO_MAX) begin
      scale = ratio;
    end else begin
      k = 64'h1_0000 + ((big << 8) / e);
      if (k > 64'h2_0000_0000) k = 64'h2_0000_0000;
      prod = 128'(ratio) * 128'(k);
      scale = prod[79:16];
      if (scale > 64'h1_0000_0000) scale = 64'h1_0000_0000;
    end
    for (int i = 0; i < 3; i++) begin
      c = ch[i];
      if (c > 64'h2_0000) c = 64'h2_0000;
      q[i] = gamma_code(c * scale);
    end
    return '{r: q[0], g: q[1], b: q[2]};
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Driver: presents pending pixels, with random idle bursts until the calm tail.
  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        expected_pixels.push_back(tone_map(pending_pixels.pop_front(), exposure_shadow));
      end
      if (!(pix.valid && !pix.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          pix.valid <= 1'b0;
        end else if (pending_pixels.size() > 0 && !cfg_we) begin
          // A new transaction starts; sometimes an idle burst follows it.
          pix.valid    <= 1'b1;
          pix.red_in   <= pending_pixels[0].r;
          pix.green_in <= pending_pixels[0].g;
          pix.blue_in  <= pending_pixels[0].b;
          if (!calm_tail && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 9);
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each output transaction with the oldest expected pixel.
  always @(posedge clk) begin
    if (rst) begin
      rgb.ready <= 1'b0;
    end else begin
      if (rgb.valid && rgb.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("unexpected output pixel");
          error_count++;
        end else begin
          ldr_pix_t want;
          want = expected_pixels.pop_front();
          if (rgb.red_out   !== want.r) report_mismatch("red", rgb.red_out, want.r);
          if (rgb.green_out !== want.g) report_mismatch("green", rgb.green_out, want.g);
          if (rgb.blue_out  !== want.b) report_mismatch("blue", rgb.blue_out, want.b);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        rgb.ready <= 1'b0;
      end else begin
        rgb.ready <= 1'b1;
        if (!calm_tail && $urandom_range(0, 6) == 0) out_gap = $urandom_range(1, 9);
      end
    end
  end

  // Watchdog: counts cycles in which neither side completes a transaction.
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (rgb.valid && rgb.ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 32'h0000_FFFF);
      1: return $urandom_range(0, 32'h0002_FFFF);
      2: return $urandom_range(0, 32'h0000_1000);
      3: return {8'($urandom_range(0, 255)), 24'(0)} | 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  task automatic add_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
    pending_pixels.push_back('{r: r, g: g, b: b});
  endtask

  // Waits until every expected pixel has come out, then lets the pipeline settle.
  task automatic drain_pipeline();
    wait (pending_pixels.size() == 0 && expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the exposure register while the pipeline is empty.
  task automatic write_exposure(logic [rtm_pkg::EXPO_W-1:0] value);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    exposure_shadow = value;
    @(posedge clk);
  endtask

  initial begin
    logic [rtm_pkg::EXPO_W-1:0] settings[8];
    settings = '{12'd2560, 12'd26, 12'd0, 12'd1, 12'd4095, 12'd2559, 12'd256, 12'd1000};
    pix.valid = 1'b0;
    pix.red_in = '0;
    pix.green_in = '0;
    pix.blue_in = '0;
    rgb.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 8; phase++) begin
      if (phase > 0) write_exposure(settings[phase]);
      // Directed part: zeros, full scale, unity, the cap boundaries, single lit channels and a mix.
      add_pixel(0, 0, 0);
      add_pixel('1, '1, '1);
      add_pixel(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      add_pixel(32'h0002_0000, 32'h0001_FFFF, 32'h0002_0001);
      add_pixel(32'd1, 32'd0, 32'd0);
      add_pixel(32'd0, 32'h8000_0000, 32'd0);
      add_pixel(32'd0, 32'd0, 32'h0000_8000);
      add_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_4000);
      for (int i = 0; i < 125; i++) begin
        if (phase == 7 && i == 60) calm_tail = 1'b1;
        add_pixel(rand_chan(), rand_chan(), rand_chan());
      end
    end
    drain_pipeline();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== hdr_reinhard_tone_mapper.f =====
+incdir+design
design/rtm_pkg.sv
design/rtm_if.sv
design/rtm_div_pipe.sv
design/rtm_scale.sv
design/rtm_gamma.sv
design/hdr_reinhard_tone_mapper.sv
verif/hdr_reinhard_tone_mapper_tb.sv
